// File: src/fpa_pkg.sv
// package for the q24.8 fixed-point alu: opcodes, widths, defaults
// no dependencies
`default_nettype none
package fpa_pkg;
   localparam int DefFracBits = 8;
   localparam int DefDataWidth = 32;
   localparam int FieldWidth = 32;
   localparam int OpWidth = 4;

   typedef enum logic [OpWidth-1:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
      OP_LT = 4'd4, OP_GT = 4'd5, OP_LE = 4'd6, OP_GE = 4'd7,
      OP_EQ = 4'd8, OP_NE = 4'd9, OP_INC = 4'd10, OP_DEC = 4'd11,
      OP_FROM_INT = 4'd12, OP_TO_INT = 4'd13
   } op_type;
endpackage
`default_nettype wire

// File: src/fpa_div_pipe.sv
// pipelined restoring divider on magnitudes, one quotient bit per stage
// does not use fpa_pkg; the top level sets its widths
`default_nettype none
module fpa_div_pipe #(
   parameter int NumWidth = 40,
   parameter int DenWidth = 32
) (
   input  wire logic                clock,
   input  wire logic                enable,
   input  wire logic [NumWidth-1:0] num,
   input  wire logic [DenWidth-1:0] den,
   output logic      [NumWidth-1:0] quo
);
   logic [NumWidth-1:0] q_ff [NumWidth+1];
   logic [DenWidth:0]   r_ff [NumWidth+1];
   logic [DenWidth-1:0] d_ff [NumWidth+1];

   always_comb begin
      q_ff[0] = num;
      r_ff[0] = '0;
      d_ff[0] = den;
   end

   for (genvar s = 0; s < NumWidth; s++) begin : g_stage
      logic [DenWidth:0]   trial;
      logic [DenWidth+1:0] diff;
      logic [NumWidth-1:0] q_in;
      logic [DenWidth:0]   r_in;
      always_comb begin
         trial = {r_ff[s][DenWidth-1:0], q_ff[s][NumWidth-1]};
         diff = {1'b0, trial} - {2'b0, d_ff[s]};
         q_in = {q_ff[s][NumWidth-2:0], ~diff[DenWidth+1]};
         r_in = diff[DenWidth+1] ? trial : diff[DenWidth:0];
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            q_ff[s+1] <= q_in;
            r_ff[s+1] <= r_in;
            d_ff[s+1] <= d_ff[s];
         end
      end
   end

   assign quo = q_ff[NumWidth];
endmodule
`default_nettype wire

// File: src/fixed_point_q24_8_alu.sv
// top level of the q24.8 fixed-point alu, stream in, stream out
// depends on fpa_pkg and fpa_div_pipe
//
// channel | dir | tdata (low bit up)
// req     | in  | req_type[3:0], operand_a[35:4], operand_b[67:36], zero pad to 72
// rsp     | out | result_value[31:0], compare_flag[32], divide_by_zero[33], pad to 40
//
// the one-bit-per-stage divider sets the depth of the pipe;
// one word enters per cycle unless rsp stalls. reset clears valid bits only. a stall on rsp
// freezes the whole pipe; the output register frees when taken.
`default_nettype none
module fixed_point_q24_8_alu #(
   parameter int FRAC_BITS  = fpa_pkg::DefFracBits,
   parameter int DATA_WIDTH = fpa_pkg::DefDataWidth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // req_type, operand_a, operand_b
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata    // result_value, compare_flag, divide_by_zero
);
   localparam int DW = DATA_WIDTH;
   localparam int NW = DATA_WIDTH + FRAC_BITS;
   localparam int FW = fpa_pkg::FieldWidth;
   localparam int DEPTH = NW - 1;

   logic enable;
   logic [DEPTH:0] v_ff;
   assign enable = ~rsp_tvalid | rsp_tready;
   assign req_tready = enable;

   // stage 0: operands
   fpa_pkg::op_type op0;
   logic signed [DW-1:0] a0, b0;
   assign op0 = fpa_pkg::op_type'(req_tdata[3:0]);
   assign a0 = req_tdata[4 +: DW];
   assign b0 = req_tdata[36 +: DW];

   logic signed [DW-1:0] simple0;
   logic cmp0;
   always_comb begin
      simple0 = '0;
      cmp0 = 1'b0;
      case (op0)
         fpa_pkg::OP_ADD: simple0 = a0 + b0;
         fpa_pkg::OP_SUB: simple0 = a0 - b0;
         fpa_pkg::OP_LT: cmp0 = a0 < b0;
         fpa_pkg::OP_GT: cmp0 = a0 > b0;
         fpa_pkg::OP_LE: cmp0 = a0 <= b0;
         fpa_pkg::OP_GE: cmp0 = a0 >= b0;
         fpa_pkg::OP_EQ: cmp0 = a0 == b0;
         fpa_pkg::OP_NE: cmp0 = a0 != b0;
         fpa_pkg::OP_INC: simple0 = a0 + DW'(1);
         fpa_pkg::OP_DEC: simple0 = a0 - DW'(1);
         fpa_pkg::OP_FROM_INT: simple0 = a0 << FRAC_BITS;
         fpa_pkg::OP_TO_INT: simple0 = a0 >>> FRAC_BITS;
         default: simple0 = '0;
      endcase
   end

   // divider operands as magnitudes
   logic [NW-1:0] num_mag;
   logic [DW-1:0] den_mag;
   logic signed [NW-1:0] num_s;
   assign num_s = NW'(a0) <<< FRAC_BITS;
   assign num_mag = num_s[NW-1] ? NW'(-num_s) : NW'(num_s);
   assign den_mag = b0[DW-1] ? DW'(-b0) : DW'(b0);

   // first stage: multiply
   logic signed [2*DW-1:0] prod_ff;
   logic signed [DW-1:0] simple_ff [DEPTH+1];
   logic [DEPTH:0] cmp_ff, mul_ff, div_ff, neg_ff, dz_ff;
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= a0 * b0;
      end
   end

   logic [NW-1:0] quo;
   fpa_div_pipe #(.NumWidth(NW), .DenWidth(DW)) u_div (
      .clock(clock), .enable(enable), .num(num_mag), .den(den_mag), .quo(quo)
   );

   // product shifted and held through the pipe
   logic signed [DW-1:0] mulres_ff [1:DEPTH];
   logic signed [2*DW-1:0] prod_sh;
   assign prod_sh = prod_ff >>> FRAC_BITS;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (enable) begin
         v_ff <= {v_ff[DEPTH-1:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         simple_ff[0] <= simple0;
         cmp_ff[0] <= cmp0;
         mul_ff[0] <= op0 == fpa_pkg::OP_MUL;
         div_ff[0] <= op0 == fpa_pkg::OP_DIV && b0 != '0;
         dz_ff[0] <= op0 == fpa_pkg::OP_DIV && b0 == '0;
         neg_ff[0] <= a0[DW-1] ^ b0[DW-1];
         mulres_ff[1] <= prod_sh[DW-1:0];
         for (int i = 1; i <= DEPTH; i++) begin
            simple_ff[i] <= simple_ff[i-1];
            cmp_ff[i] <= cmp_ff[i-1];
            mul_ff[i] <= mul_ff[i-1];
            div_ff[i] <= div_ff[i-1];
            dz_ff[i] <= dz_ff[i-1];
            neg_ff[i] <= neg_ff[i-1];
         end
         for (int i = 2; i <= DEPTH; i++) begin
            mulres_ff[i] <= mulres_ff[i-1];
         end
      end
   end

   // final stage aligns with divider output after NW stages, plus sign fix
   localparam int QS = NW - 1;
   logic [NW-1:0] qsign;
   logic signed [DW-1:0] res_in;
   assign qsign = neg_ff[QS] ? NW'(-quo) : quo;
   always_comb begin
      if (div_ff[QS]) res_in = qsign[DW-1:0];
      else if (mul_ff[QS]) res_in = mulres_ff[QS];
      else res_in = simple_ff[QS];
   end

   logic signed [DW-1:0] res_ff;
   logic rcmp_ff, rdz_ff, rv_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (enable) begin
         rv_ff <= v_ff[QS];
      end
   end
   always_ff @(posedge clock) begin
      if (enable) begin
         res_ff <= res_in;
         rcmp_ff <= cmp_ff[QS];
         rdz_ff <= dz_ff[QS];
      end
   end

   logic [FW-1:0] res_ext;
   assign res_ext = FW'(res_ff);
   assign rsp_tvalid = rv_ff;
   assign rsp_tdata = {6'b0, rdz_ff, rcmp_ff, res_ext};

`ifndef SYNTH
   a_dz_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[33] |-> rsp_tdata[31:0] == '0 && !rsp_tdata[32])
      else $error("divide by zero with nonzero result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("pipe blocked while output empty");
`endif
endmodule
`default_nettype wire
